@@ rtl/core/dfw_pkg.sv @@
`default_nettype none

package dfw_pkg;

    // Sizing of the graph storage.
    localparam int MAX_VERTICES = 16;
    localparam int MAX_DEGREE   = 16;

    // Field widths fixed by the interface.
    localparam int VTX_W        = 4;
    localparam int CNT_W        = VTX_W + 1;
    localparam int CFG_W        = 5;
    localparam int CMD_W        = 2;
    localparam int ST_W         = 2;
    localparam int VERTEX_SLOTS = 1 << VTX_W;

    // Vertices that can be addressed at all.
    localparam int VERTEX_CAP = (MAX_VERTICES < VERTEX_SLOTS) ? MAX_VERTICES : VERTEX_SLOTS;

    // Derived storage widths.
    localparam int LEN_W     = $clog2(MAX_DEGREE + 1);
    localparam int TBL_DEPTH = VERTEX_CAP * MAX_DEGREE;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int STK_IDX_W = $clog2(MAX_VERTICES);
    localparam int DEPTH_W   = $clog2(MAX_VERTICES + 1);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Vertex count register reset value.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_VISIT  = 1'b1;

    // Operations after classification by the front.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_ADD,
        OP_SEARCH,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] neighbor;
    } t_cmd;

    // A queue slot as it moves between modules.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qitem;

    // One frame of the walk stack.
    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic [LEN_W-1:0] pos;
    } t_frame;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] vertex;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_result;

    // Address of entry pos in the list of vertex v.
    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [VTX_W-1:0] v,
                                                   input logic [LEN_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(v) * ADDR_W'(MAX_DEGREE));
        return base + ADDR_W'(pos);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/graph_depth_first_walk.sv @@
// Depth-first walk over a small adjacency table. Clear, add and rejected
// commands each give one status result in the back end. A search from
// vertex s gives one report per reachable vertex, in recursive depth-first
// order, the final one flagged last; for each list entry it makes one
// registered read of the neighbor table and then one check, and it pops a
// stack frame when a list is used up. The front takes items into a
// two-entry queue while the back works, so input stalls only when that
// queue is full. The vertex count register may be written only while idle.
`default_nettype none

module graph_depth_first_walk
    import dfw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [VTX_W-1:0] i_vertex,
    input  wire logic [VTX_W-1:0] i_neighbor,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_kind,
    output logic      [VTX_W-1:0] o_visited_vertex,
    output logic      [ST_W-1:0]  o_status,
    output logic                  o_last,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_qitem           push;
    t_qitem           head;
    logic             q_full;
    logic             pop;
    logic [CNT_W-1:0] count;
    t_result          result;

    dfw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_vertex    (i_vertex),
        .i_neighbor  (i_neighbor),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_count     (count)
    );

    dfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    dfw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_count  (count),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    // Result fields on their own ports.
    assign o_kind           = result.kind;
    assign o_visited_vertex = result.vertex;
    assign o_status         = result.status;
    assign o_last           = result.last;

endmodule

`default_nettype wire

@@ rtl/core/dfw_ram.sv @@
`default_nettype none

module dfw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dfw_front.sv @@
`default_nettype none

module dfw_front
    import dfw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [VTX_W-1:0] i_vertex,
    input  wire logic [VTX_W-1:0] i_neighbor,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_q_full,
    output t_qitem                o_push,
    output logic      [CNT_W-1:0] o_count
);

    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] count;
    logic             vtx_bad;
    logic             nb_bad;
    logic             accept;

    // Vertex count register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Effective count, saturated to the addressable range; zero counts as one.
    always_comb begin
        if (r_cfg == '0) begin
            count = CNT_W'(1);
        end else if (CNT_W'(r_cfg) > CNT_W'(VERTEX_CAP)) begin
            count = CNT_W'(VERTEX_CAP);
        end else begin
            count = CNT_W'(r_cfg);
        end
    end

    assign o_count = count;
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign vtx_bad = CNT_W'(i_vertex) >= count;
    assign nb_bad  = CNT_W'(i_neighbor) >= count;

    // Classify the item; the unused command is taken and dropped.
    always_comb begin
        o_push.valid        = 1'b0;
        o_push.cmd.op       = OP_CLEAR;
        o_push.cmd.vertex   = i_vertex;
        o_push.cmd.neighbor = i_neighbor;
        case (i_command)
            CMD_CLEAR: begin
                o_push.valid  = accept;
                o_push.cmd.op = OP_CLEAR;
            end
            CMD_ADD: begin
                o_push.valid  = accept;
                o_push.cmd.op = (vtx_bad || nb_bad) ? OP_REJECT : OP_ADD;
            end
            CMD_SEARCH: begin
                o_push.valid  = accept;
                o_push.cmd.op = vtx_bad ? OP_REJECT : OP_SEARCH;
            end
            default: begin
                o_push.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dfw_queue.sv @@
`default_nettype none

module dfw_queue
    import dfw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qitem i_push,
    input  wire logic   i_pop,
    output logic        o_full,
    output t_qitem      o_head
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;
    logic              do_pop;

    assign o_full       = r_fill == QCNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_fill != '0;
    assign o_head.cmd   = r_slot[r_rd_ptr];
    assign do_pop       = i_pop && (r_fill != '0);

    // Slots hold payload only; pointers and fill are control.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !i_push.valid) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dfw_back.sv @@
`default_nettype none

module dfw_back
    import dfw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_qitem           i_head,
    output logic                  o_pop,
    input  wire logic [CNT_W-1:0] i_count,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_result               o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len [VERTEX_SLOTS];
    logic [LEN_W-1:0]   n_len [VERTEX_SLOTS];
    t_frame             r_stack [MAX_VERTICES];
    t_frame             n_stack [MAX_VERTICES];
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [VERTEX_SLOTS-1:0] r_visited, n_visited;
    logic [VTX_W-1:0]   r_pend, n_pend;
    logic               r_o_valid, n_o_valid;
    t_result            r_out, n_out;

    logic               can_emit;
    logic [STK_IDX_W-1:0] top_idx;
    t_frame             top;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VTX_W-1:0]   rd_nb;
    logic [DEPTH_W-1:0] depth_dec;

    // Neighbor lists, one slot per vertex and list position.
    dfw_ram #(
        .WIDTH(VTX_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_head.cmd.neighbor),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_nb)
    );

    assign can_emit  = !r_o_valid || !i_stall;
    assign depth_dec = r_depth - 1'b1;
    assign top_idx   = depth_dec[STK_IDX_W-1:0];
    assign top       = r_stack[top_idx];
    assign o_valid   = r_o_valid;
    assign o_result  = r_out;

    // Command execution and the depth-first walk. A found vertex is held back
    // one step so the final report can carry the last flag.
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_stack   = r_stack;
        n_depth   = r_depth;
        n_visited = r_visited;
        n_pend    = r_pend;
        n_o_valid = r_o_valid && i_stall;
        n_out     = r_out;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = tbl_addr(i_head.cmd.vertex, r_len[i_head.cmd.vertex]);
        rd_en     = 1'b0;
        rd_addr   = tbl_addr(top.vtx, top.pos);
        case (r_state)
            S_IDLE: begin
                if (i_head.valid && can_emit) begin
                    o_pop = 1'b1;
                    n_out = '{kind: KIND_STATUS, vertex: '0, status: ST_OK, last: 1'b1};
                    case (i_head.cmd.op)
                        OP_CLEAR: begin
                            n_o_valid = 1'b1;
                            for (int i = 0; i < VERTEX_SLOTS; i++) begin
                                n_len[i] = '0;
                            end
                        end
                        OP_ADD: begin
                            n_o_valid = 1'b1;
                            if (r_len[i_head.cmd.vertex] >= LEN_W'(MAX_DEGREE)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                n_len[i_head.cmd.vertex] = r_len[i_head.cmd.vertex] + 1'b1;
                            end
                        end
                        OP_REJECT: begin
                            n_o_valid    = 1'b1;
                            n_out.status = ST_RANGE;
                        end
                        OP_SEARCH: begin
                            n_visited  = '0;
                            n_visited[i_head.cmd.vertex] = 1'b1;
                            n_pend     = i_head.cmd.vertex;
                            n_stack[0] = '{vtx: i_head.cmd.vertex, pos: '0};
                            n_depth    = DEPTH_W'(1);
                            n_state    = S_LOOK;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (r_depth == '0) begin
                    n_state = S_FINISH;
                end else if (top.pos >= r_len[top.vtx]) begin
                    n_depth = depth_dec;
                end else begin
                    rd_en                = 1'b1;
                    n_stack[top_idx].pos = top.pos + 1'b1;
                    n_state              = S_CHECK;
                end
            end
            S_CHECK: begin
                if (CNT_W'(rd_nb) >= i_count || r_visited[rd_nb]) begin
                    n_state = S_LOOK;
                end else if (can_emit) begin
                    n_o_valid        = 1'b1;
                    n_out            = '{kind: KIND_VISIT, vertex: r_pend, status: ST_OK,
                                         last: 1'b0};
                    n_pend           = rd_nb;
                    n_visited[rd_nb] = 1'b1;
                    if (r_depth < DEPTH_W'(MAX_VERTICES)) begin
                        n_stack[r_depth[STK_IDX_W-1:0]] = '{vtx: rd_nb, pos: '0};
                        n_depth = r_depth + 1'b1;
                    end
                    n_state = S_LOOK;
                end
            end
            S_FINISH: begin
                if (can_emit) begin
                    n_o_valid = 1'b1;
                    n_out     = '{kind: KIND_VISIT, vertex: r_pend, status: ST_OK, last: 1'b1};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, walk storage and the output register.
    always_ff @(posedge i_clk) begin
        r_stack <= n_stack;
        r_pend  <= n_pend;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_visited <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < VERTEX_SLOTS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_visited <= n_visited;
            r_o_valid <= n_o_valid;
            r_len     <= n_len;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dfw_checker.sv @@
`default_nettype none

module dfw_checker
    import dfw_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic             o_kind,
    input wire logic [VTX_W-1:0] o_visited_vertex,
    input wire logic [ST_W-1:0]  o_status,
    input wire logic             o_last
);

    // A stalled result item stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_kind, o_visited_vertex, o_status, o_last}))
        else $error("result payload changed while stalled");

    // A visit report always carries an ok status.
    a_visit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_VISIT |-> o_status == ST_OK)
        else $error("visit report with nonzero status");

    // A status result is the only result of its item, names no vertex and carries a known status code.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_STATUS |-> o_last && o_visited_vertex == '0
        && (o_status == ST_OK || o_status == ST_FULL || o_status == ST_RANGE))
        else $error("malformed status result");

endmodule

bind graph_depth_first_walk dfw_checker u_dfw_checker (.*);

`default_nettype wire
